### sv/mmqe_pkg.sv
// ----------------------------------------------------------------------------
// mmqe_pkg
// Types and constants shared by the quote engine and its channel interfaces.
// ----------------------------------------------------------------------------
package mmqe_pkg;

  localparam int DEF_SYMBOLS = 64;

  localparam logic OP_FEATURE = 1'b0;
  localparam logic OP_FILL    = 1'b1;

  localparam logic KIND_CANCEL = 1'b0;
  localparam logic KIND_SUBMIT = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [2:0] REG_MAX_INV  = 3'd0;
  localparam logic [2:0] REG_INV_SKEW = 3'd1;
  localparam logic [2:0] REG_FLOW     = 3'd2;
  localparam logic [2:0] REG_HALF     = 3'd3;
  localparam logic [2:0] REG_THRESH   = 3'd4;
  localparam logic [2:0] REG_COOL     = 3'd5;
  localparam logic [2:0] REG_QTY      = 3'd6;

  typedef struct packed {
    logic [47:0]        bid_order;
    logic [47:0]        ask_order;
    logic               bid_live;
    logic               ask_live;
    logic               center_valid;
    logic signed [31:0] position;
    logic signed [31:0] prior_center;
    logic [63:0]        requote_time;
  } slot_rec_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_ROUND,
    ST_DECIDE,
    ST_CAN_BID,
    ST_CAN_ASK,
    ST_SUB_BID,
    ST_SUB_ASK,
    ST_SCAN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
    logic signed [31:0] r;
    if (x > 51'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### sv/mmqe_if.sv
// ----------------------------------------------------------------------------
// mmqe channel interfaces
// Valid/ready channels for input items and for quote actions.
// ----------------------------------------------------------------------------
interface mmqe_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         symbol_slot;
  logic signed [47:0] microprice_q16;
  logic signed [31:0] flow_imbalance_q16;
  logic [63:0]        timestamp_ns;
  logic [47:0]        fill_id;
  logic               fill_side;
  logic [31:0]        fill_qty;
  logic               fill_partial;

  modport source (output valid, operation, symbol_slot, microprice_q16, flow_imbalance_q16,
                  timestamp_ns, fill_id, fill_side, fill_qty, fill_partial, input ready);
  modport sink (input valid, operation, symbol_slot, microprice_q16, flow_imbalance_q16,
                timestamp_ns, fill_id, fill_side, fill_qty, fill_partial, output ready);
endinterface

interface mmqe_out_if;
  logic               valid;
  logic               ready;
  logic               action_kind;
  logic               order_side;
  logic [5:0]         out_slot;
  logic [47:0]        out_order_id;
  logic signed [31:0] price_ticks;
  logic [31:0]        out_qty;
  logic [63:0]        out_time_ns;
  logic               last;

  modport source (output valid, action_kind, order_side, out_slot, out_order_id, price_ticks,
                  out_qty, out_time_ns, last, input ready);
  modport sink (input valid, action_kind, order_side, out_slot, out_order_id, price_ticks,
                out_qty, out_time_ns, last, output ready);
endinterface

### sv/market_making_quote_engine_core.sv
// ----------------------------------------------------------------------------
// market_making_quote_engine_core
// Per-slot quoting engine: center price, requote decision, fill tracking.
// ----------------------------------------------------------------------------
// channel   dir  transaction
// in_ch     in   feature update or fill report
// out_ch    out  cancel or submit action, up to four per feature
// apb       in   register writes and reads
//
// A feature passes through the LOAD, MUL1, MUL2, SUM, ROUND and DECIDE states and
// then a state per action; one multiplier is reused for both skew products. A
// fill scans the slot table, one slot per cycle, stopping early on a match.
// After reset a clearing pass zeroes the table before the first item is taken.
// A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module market_making_quote_engine_core import mmqe_pkg::*; #(
  parameter int SYMBOLS = DEF_SYMBOLS
) (
  input  logic        clk,
  input  logic        rst,
  mmqe_in_if.sink     in_ch,
  mmqe_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOLS - 1);

  logic [30:0]        inv_limit;
  logic signed [31:0] inventory_skew;
  logic signed [31:0] flow_skew_coef;
  logic [15:0]        half_spread;
  logic [15:0]        requote_threshold;
  logic [39:0]        cooldown_ns;
  logic [31:0]        quote_qty;

  state_t state, state_next;

  slot_rec_t mem [SYMBOLS];
  slot_rec_t rd_data, cur, wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr, clr_idx, scan_idx, chk_idx, slot_idx;
  logic             wr_en, chk_valid, issue_on;

  logic [5:0]         slot_q;
  logic signed [47:0] micro_q;
  logic signed [31:0] ofi_q;
  logic [63:0]        ts_q;
  logic [47:0]        fid_q;
  logic               fside_q, fpart_q;
  logic [31:0]        fqty_q;

  logic signed [31:0] inv, mul_a, mul_b, center, bid_px, ask_px;
  logic signed [63:0] prod, acc;
  logic signed [81:0] tot;
  logic [47:0]        id_counter, nb_id, na_id;

  logic [12:0] in_slot_ext;
  logic        in_slot_ok, in_take, out_load, go, bm, am, match;
  logic signed [31:0] lim, clamp_v, c_next;
  logic signed [50:0] q_r;
  logic               rnd;
  logic signed [32:0] dlt, dabs;
  logic [63:0]        tdiff;
  logic               want, cool;
  logic signed [33:0] pos_sum;

  logic               o_kind, o_side, o_last;
  logic [47:0]        o_id;
  logic signed [31:0] o_px;
  logic [31:0]        o_qty;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[5:3])
      REG_MAX_INV:  prdata = {33'd0, inv_limit};
      REG_INV_SKEW: prdata = {32'd0, inventory_skew};
      REG_FLOW:     prdata = {32'd0, flow_skew_coef};
      REG_HALF:     prdata = {48'd0, half_spread};
      REG_THRESH:   prdata = {48'd0, requote_threshold};
      REG_COOL:     prdata = {24'd0, cooldown_ns};
      REG_QTY:      prdata = {32'd0, quote_qty};
      default:      prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_limit         <= 31'd100;
      inventory_skew    <= 32'sd0;
      flow_skew_coef    <= 32'sd0;
      half_spread       <= 16'd1;
      requote_threshold <= 16'd1;
      cooldown_ns       <= 40'd0;
      quote_qty         <= 32'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_MAX_INV:  inv_limit         <= pwdata[30:0];
        REG_INV_SKEW: inventory_skew    <= pwdata[31:0];
        REG_FLOW:     flow_skew_coef    <= pwdata[31:0];
        REG_HALF:     half_spread       <= pwdata[15:0];
        REG_THRESH:   requote_threshold <= pwdata[15:0];
        REG_COOL:     cooldown_ns       <= pwdata[39:0];
        REG_QTY:      quote_qty         <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  assign in_slot_ext = 13'(in_ch.symbol_slot);
  assign in_slot_ok  = in_slot_ext < 13'(SYMBOLS);
  assign slot_idx    = IDX_W'(13'(slot_q));
  assign in_take     = in_ch.valid && in_ch.ready;

  // datapath helpers
  always_comb begin
    lim = $signed({1'b0, inv_limit});
    if (rd_data.position > lim) begin
      clamp_v = lim;
    end else if (rd_data.position < -lim) begin
      clamp_v = -lim;
    end else begin
      clamp_v = rd_data.position;
    end
    rnd = tot[81] ? (tot[31] && (|tot[30:0])) : tot[31];
    q_r = $signed(tot[81:32]) + $signed({50'd0, rnd});
    c_next = sat32(q_r);
    dlt  = 33'(center) - 33'(cur.prior_center);
    dabs = dlt[32] ? -dlt : dlt;
    want = !cur.center_valid || (dabs >= $signed({17'd0, requote_threshold}));
    tdiff = ts_q - cur.requote_time;
    cool = (ts_q >= cur.requote_time) && (tdiff >= {24'd0, cooldown_ns});
    go = want && cool;
    bm = rd_data.bid_live && (rd_data.bid_order == fid_q);
    am = rd_data.ask_live && (rd_data.ask_order == fid_q);
    match = chk_valid && (bm || am);
    pos_sum = fside_q ? (34'(rd_data.position) - $signed({2'b0, fqty_q}))
                      : (34'(rd_data.position) + $signed({2'b0, fqty_q}));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_take && in_ch.operation == OP_FILL) begin
          state_next = ST_SCAN;
        end else if (in_take && in_slot_ok) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:    state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_MUL2;
      ST_MUL2:    state_next = ST_SUM;
      ST_SUM:     state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        priority if (!go)          state_next = ST_IDLE;
        else if (cur.bid_live)     state_next = ST_CAN_BID;
        else if (cur.ask_live)     state_next = ST_CAN_ASK;
        else                       state_next = ST_SUB_BID;
      end
      ST_CAN_BID: if (out_load) state_next = cur.ask_live ? ST_CAN_ASK : ST_SUB_BID;
      ST_CAN_ASK: if (out_load) state_next = ST_SUB_BID;
      ST_SUB_BID: if (out_load) state_next = ST_SUB_ASK;
      ST_SUB_ASK: if (out_load) state_next = ST_IDLE;
      ST_SCAN: begin
        if (match || (chk_valid && chk_idx == LAST_IDX)) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    rd_addr  = slot_idx;
    wr_en    = 1'b0;
    wr_addr  = slot_idx;
    wr_data  = cur;
    mul_a    = inv;
    mul_b    = inventory_skew;
    out_load = 1'b0;
    o_kind   = KIND_CANCEL;
    o_side   = SIDE_BUY;
    o_id     = cur.bid_order;
    o_px     = 32'sd0;
    o_qty    = 32'd0;
    o_last   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      ST_IDLE:  rd_addr = in_slot_ext[IDX_W-1:0];
      ST_MUL2: begin
        mul_a = ofi_q;
        mul_b = flow_skew_coef;
      end
      ST_DECIDE: begin
        wr_en = go;
        wr_data.bid_order    = id_counter;
        wr_data.ask_order    = id_counter + 48'd1;
        wr_data.bid_live     = 1'b1;
        wr_data.ask_live     = 1'b1;
        wr_data.center_valid = 1'b1;
        wr_data.prior_center = center;
        wr_data.requote_time = ts_q;
      end
      ST_CAN_BID: out_load = !out_ch.valid || out_ch.ready;
      ST_CAN_ASK: begin
        out_load = !out_ch.valid || out_ch.ready;
        o_side   = SIDE_SELL;
        o_id     = cur.ask_order;
      end
      ST_SUB_BID: begin
        out_load = !out_ch.valid || out_ch.ready;
        o_kind   = KIND_SUBMIT;
        o_id     = nb_id;
        o_px     = bid_px;
        o_qty    = quote_qty;
      end
      ST_SUB_ASK: begin
        out_load = !out_ch.valid || out_ch.ready;
        o_kind   = KIND_SUBMIT;
        o_side   = SIDE_SELL;
        o_id     = na_id;
        o_px     = ask_px;
        o_qty    = quote_qty;
        o_last   = 1'b1;
      end
      ST_SCAN: begin
        rd_addr = scan_idx;
        wr_addr = chk_idx;
        wr_en   = match;
        wr_data = rd_data;
        wr_data.position     = sat32(51'(pos_sum));
        wr_data.center_valid = 1'b0;
        if (!fpart_q && bm) begin
          wr_data.bid_live  = 1'b0;
          wr_data.bid_order = 48'd0;
        end
        if (!fpart_q && am) begin
          wr_data.ask_live  = 1'b0;
          wr_data.ask_order = 48'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      id_counter <= 48'd1;
      out_ch.valid <= 1'b0;
      chk_valid  <= 1'b0;
      issue_on   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == ST_DECIDE && go) id_counter <= id_counter + 48'd2;
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (state == ST_IDLE) begin
        chk_valid <= 1'b0;
        issue_on  <= 1'b1;
      end else if (state == ST_SCAN) begin
        chk_valid <= issue_on;
        if (scan_idx == LAST_IDX) issue_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_take) begin
      slot_q  <= in_ch.symbol_slot;
      micro_q <= in_ch.microprice_q16;
      ofi_q   <= in_ch.flow_imbalance_q16;
      ts_q    <= in_ch.timestamp_ns;
      fid_q   <= in_ch.fill_id;
      fside_q <= in_ch.fill_side;
      fqty_q  <= in_ch.fill_qty;
      fpart_q <= in_ch.fill_partial;
    end
    if (state == ST_IDLE) scan_idx <= '0;
    if (state == ST_SCAN) begin
      chk_idx <= scan_idx;
      if (scan_idx != LAST_IDX) scan_idx <= scan_idx + 1'b1;
    end
    if (state == ST_LOAD) begin
      cur <= rd_data;
      inv <= clamp_v;
    end
    if (state == ST_MUL2) acc <= 64'(micro_q) - prod;
    if (state == ST_SUM) tot <= {{2{acc[63]}}, acc, 16'd0} - 82'(prod);
    if (state == ST_ROUND) center <= c_next;
    if (state == ST_DECIDE) begin
      nb_id  <= id_counter;
      na_id  <= id_counter + 48'd1;
      bid_px <= sat32(51'(center) - $signed({35'd0, half_spread}));
      ask_px <= sat32(51'(center) + $signed({35'd0, half_spread}));
    end
    if (out_load) begin
      out_ch.action_kind  <= o_kind;
      out_ch.order_side   <= o_side;
      out_ch.out_slot     <= slot_q;
      out_ch.out_order_id <= o_id;
      out_ch.price_ticks  <= o_px;
      out_ch.out_qty      <= o_qty;
      out_ch.out_time_ns  <= ts_q;
      out_ch.last         <= o_last;
    end
  end

endmodule
